>>> rtl/slc_pkg.sv
// Shared types, character codes and helpers for the source line classifier.
// No dependencies; every other file imports this package.
package slc_pkg;

   localparam int FIELD_WIDTH = 32;

   typedef logic [7:0]             byte_type;
   typedef logic [FIELD_WIDTH-1:0] field_type;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_EOF  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      LC_EMPTY   = 2'd0,
      LC_COMMENT = 2'd1,
      LC_CODE    = 2'd2,
      LC_NONE    = 2'd3
   } line_class_type;

   localparam byte_type CH_NUL   = 8'h00;
   localparam byte_type CH_TAB   = 8'h09;
   localparam byte_type CH_NL    = 8'h0A;
   localparam byte_type CH_CR    = 8'h0D;
   localparam byte_type CH_SPACE = 8'h20;
   localparam byte_type CH_STAR  = 8'h2A;
   localparam byte_type CH_SLASH = 8'h2F;

   // One finished line (or end of file) as seen by the counters.
   typedef struct packed {
      logic           fire;
      line_class_type line_class;
      logic           done;
   } line_event_type;

   typedef struct packed {
      field_type empty;
      field_type comment;
      field_type code;
   } counts_type;

   function automatic logic is_space(input byte_type b);
      return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
   endfunction

   function automatic line_class_type classify(input logic not_blank, input logic has_code);
      line_class_type cls;
      if (!not_blank) begin
         cls = LC_EMPTY;
      end else if (has_code) begin
         cls = LC_CODE;
      end else begin
         cls = LC_COMMENT;
      end
      return cls;
   endfunction

endpackage

>>> rtl/slc_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on slc_pkg for the payload types.
interface slc_req_if import slc_pkg::*; ();
   logic       valid;
   logic       ready;
   opcode_type opcode;
   byte_type   data_byte;

   modport source (output valid, output opcode, output data_byte, input ready);
   modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface slc_rsp_if import slc_pkg::*; ();
   logic           valid;
   logic           ready;
   line_class_type line_class;
   field_type      empty_lines;
   field_type      comment_lines;
   field_type      code_lines;
   logic           file_done;

   modport source (output valid, output line_class, output empty_lines,
                   output comment_lines, output code_lines, output file_done, input ready);
   modport sink   (input valid, input line_class, input empty_lines,
                   input comment_lines, input code_lines, input file_done, output ready);
endinterface

>>> rtl/slc_scan.sv
// Per-byte comment scanner: block-comment, pending slash/star and line flags.
// Depends on slc_pkg; emits one line event per newline or end of file.
module slc_scan import slc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  opcode_type     opcode,
   input  byte_type       data_byte,
   output line_event_type line_event
);

   logic in_block_ff,  in_block_in;
   logic slash_ff,     slash_in;
   logic star_ff,      star_in;
   logic rest_lc_ff,   rest_lc_in;
   logic has_code_ff,  has_code_in;
   logic not_blank_ff, not_blank_in;
   logic open_ff,      open_in;

   always_comb begin
      in_block_in  = in_block_ff;
      slash_in     = slash_ff;
      star_in      = star_ff;
      rest_lc_in   = rest_lc_ff;
      has_code_in  = has_code_ff;
      not_blank_in = not_blank_ff;
      open_in      = open_ff;
      line_event   = '{fire: 1'b0, line_class: LC_NONE, done: 1'b0};

      if (accept) begin
         if (opcode == OP_EOF) begin
            line_event.fire = 1'b1;
            line_event.done = 1'b1;
            line_event.line_class = open_ff ? classify(not_blank_ff, has_code_ff | slash_ff)
                                            : LC_NONE;
            in_block_in  = 1'b0;
            slash_in     = 1'b0;
            star_in      = 1'b0;
            rest_lc_in   = 1'b0;
            has_code_in  = 1'b0;
            not_blank_in = 1'b0;
            open_in      = 1'b0;
         end else begin
            open_in = 1'b1;
            if (!rest_lc_ff) begin
               if (data_byte == CH_NUL) begin
                  // NUL ends the scan like a line comment; a pending slash is code
                  if (slash_ff) begin
                     has_code_in = 1'b1;
                  end
                  slash_in   = 1'b0;
                  star_in    = 1'b0;
                  rest_lc_in = 1'b1;
               end else begin
                  if (!is_space(data_byte)) begin
                     not_blank_in = 1'b1;
                  end
                  priority if (in_block_ff) begin
                     if (star_ff && (data_byte == CH_SLASH)) begin
                        in_block_in = 1'b0;
                        star_in     = 1'b0;
                     end else begin
                        star_in = (data_byte == CH_STAR);
                     end
                  end else if (slash_ff) begin
                     slash_in = 1'b0;
                     priority if (data_byte == CH_STAR) begin
                        in_block_in = 1'b1;
                        star_in     = 1'b0;
                     end else if (data_byte == CH_SLASH) begin
                        rest_lc_in = 1'b1;
                     end else begin
                        has_code_in = 1'b1;
                     end
                  end else if (data_byte == CH_SLASH) begin
                     slash_in = 1'b1;
                  end else if (!is_space(data_byte)) begin
                     has_code_in = 1'b1;
                  end
               end
            end
            if (data_byte == CH_NL) begin
               line_event.fire       = 1'b1;
               line_event.line_class = classify(not_blank_in, has_code_in | slash_in);
               // drop per-line state, keep the block comment open across lines
               slash_in     = 1'b0;
               star_in      = 1'b0;
               rest_lc_in   = 1'b0;
               has_code_in  = 1'b0;
               not_blank_in = 1'b0;
               open_in      = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_block_ff  <= 1'b0;
         slash_ff     <= 1'b0;
         star_ff      <= 1'b0;
         rest_lc_ff   <= 1'b0;
         has_code_ff  <= 1'b0;
         not_blank_ff <= 1'b0;
         open_ff      <= 1'b0;
      end else begin
         in_block_ff  <= in_block_in;
         slash_ff     <= slash_in;
         star_ff      <= star_in;
         rest_lc_ff   <= rest_lc_in;
         has_code_ff  <= has_code_in;
         not_blank_ff <= not_blank_in;
         open_ff      <= open_in;
      end
   end

endmodule

>>> rtl/slc_count.sv
// Saturating per-file line counters, cleared when a file closes.
// Depends on slc_pkg; reports the updated counts truncated to the field width.
module slc_count import slc_pkg::*; #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  line_event_type line_event,
   output counts_type     counts
);

   localparam int ExtWidth = (COUNT_WIDTH > FIELD_WIDTH) ? COUNT_WIDTH : FIELD_WIDTH;

   typedef logic [COUNT_WIDTH-1:0] cnt_type;
   typedef logic [ExtWidth-1:0]    ext_type;

   cnt_type empty_ff,   empty_in,   empty_next;
   cnt_type comment_ff, comment_in, comment_next;
   cnt_type code_ff,    code_in,    code_next;
   ext_type empty_ext, comment_ext, code_ext;

   function automatic cnt_type sat_inc(input cnt_type v);
      return (v == '1) ? v : v + COUNT_WIDTH'(1);
   endfunction

   always_comb begin
      empty_next   = empty_ff;
      comment_next = comment_ff;
      code_next    = code_ff;
      if (line_event.fire) begin
         unique case (line_event.line_class)
            LC_EMPTY:   empty_next   = sat_inc(empty_ff);
            LC_COMMENT: comment_next = sat_inc(comment_ff);
            LC_CODE:    code_next    = sat_inc(code_ff);
            LC_NONE:    ;
            default:    ;
         endcase
      end
      // clear for the next file once the closing counts are reported
      if (line_event.fire && line_event.done) begin
         empty_in   = '0;
         comment_in = '0;
         code_in    = '0;
      end else begin
         empty_in   = empty_next;
         comment_in = comment_next;
         code_in    = code_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff   <= '0;
         comment_ff <= '0;
         code_ff    <= '0;
      end else begin
         empty_ff   <= empty_in;
         comment_ff <= comment_in;
         code_ff    <= code_in;
      end
   end

   assign empty_ext   = ExtWidth'(empty_next);
   assign comment_ext = ExtWidth'(comment_next);
   assign code_ext    = ExtWidth'(code_next);

   assign counts.empty   = empty_ext[FIELD_WIDTH-1:0];
   assign counts.comment = comment_ext[FIELD_WIDTH-1:0];
   assign counts.code    = code_ext[FIELD_WIDTH-1:0];

endmodule

>>> rtl/source_line_classifier_top.sv
// Top level of the source line classifier: scanner, counters, response register.
// Depends on slc_pkg, slc_if, slc_scan and slc_count.
//
// Usage:
//   req_chan carries one file as a stream of requests: opcode OP_BYTE with a
//   text byte in data_byte, or OP_EOF to close the file. rsp_chan gives one
//   response per finished line (at a newline byte) and one at end of file,
//   with the line's class and the running empty/comment/code counts of the
//   file; file_done marks the response that closes the file. A file ending
//   right after a newline closes with class LC_NONE.
//   A response is registered and appears in the cycle after the request that
//   causes it. Throughput: one request per cycle unless stalled; all scan and
//   count logic sits between the state registers and the response register.
//   Stall: a held response blocks a new request only when the response
//   register is full and rsp_chan.ready is low; bytes that end no line are
//   still taken in that case only when the register drains.
//   Reset (synchronous) clears comment state, line flags, counters and the
//   response valid. Counters saturate at 2^COUNT_WIDTH - 1 and clear at EOF.
module source_line_classifier_top import slc_pkg::*; #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   slc_req_if.sink   req_chan,
   slc_rsp_if.source rsp_chan
);

   logic           accept;
   line_event_type line_event;
   counts_type     counts;

   logic           rsp_valid_ff, rsp_valid_in;
   line_class_type rsp_class_ff;
   counts_type     rsp_counts_ff;
   logic           rsp_done_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   slc_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .opcode     (req_chan.opcode),
      .data_byte  (req_chan.data_byte),
      .line_event (line_event)
   );

   slc_count #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_count (
      .clock      (clock),
      .reset      (reset),
      .line_event (line_event),
      .counts     (counts)
   );

   always_comb begin
      priority if (line_event.fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load payload only on a new response; hold it while stalled
   always_ff @(posedge clock) begin
      if (line_event.fire) begin
         rsp_class_ff  <= line_event.line_class;
         rsp_counts_ff <= counts;
         rsp_done_ff   <= line_event.done;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.line_class    = rsp_class_ff;
   assign rsp_chan.empty_lines   = rsp_counts_ff.empty;
   assign rsp_chan.comment_lines = rsp_counts_ff.comment;
   assign rsp_chan.code_lines    = rsp_counts_ff.code;
   assign rsp_chan.file_done     = rsp_done_ff;

`ifndef SYNTHESIS
   a_eof_closes: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.opcode == OP_EOF)) |=> (rsp_chan.valid && rsp_chan.file_done))
      else $error("end of file did not produce a closing response");

   a_newline_line: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.opcode == OP_BYTE) && (req_chan.data_byte == CH_NL))
      |=> (rsp_chan.valid && !rsp_chan.file_done && (rsp_chan.line_class != LC_NONE)))
      else $error("newline did not produce a line response");

   a_none_only_at_eof: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.line_class == LC_NONE)) |-> rsp_chan.file_done)
      else $error("no-line class on a response that does not close the file");

   a_quiet_byte: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.opcode == OP_BYTE) && (req_chan.data_byte != CH_NL)
       && !rsp_valid_ff) |=> !rsp_chan.valid)
      else $error("response produced without end of line");
`endif

endmodule

>>> tb/tb_source_line_classifier_top.sv
// Self-checking testbench for source_line_classifier_top: streams C-like file text,
// predicts each line's class and the running counts, and checks every response.
// Depends on slc_pkg, slc_if and the classifier RTL.
module tb_source_line_classifier_top;
   import slc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int TARGET_ITEMS = 875;

   typedef struct {
      logic       pause;
      opcode_type opcode;
      byte_type   data_byte;
   } text_request_type;

   typedef struct {
      line_class_type line_class;
      field_type      empty_lines;
      field_type      comment_lines;
      field_type      code_lines;
      logic           file_done;
   } line_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   slc_req_if req_if ();
   slc_rsp_if rsp_if ();

   source_line_classifier_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   text_request_type pending_requests[$];
   line_report_type  expected_lines[$];

   // classifier state as predicted
   logic      in_block;
   logic      slash_wait;
   logic      star_wait;
   logic      skip_rest;
   logic      seen_code;
   logic      seen_text;
   logic      line_started;
   field_type n_empty;
   field_type n_comment;
   field_type n_code;

   logic req_taken;
   int   requests_taken;
   int   items_queued;
   int   error_count;
   int   cycle_count;
   int   send_gap;
   int   send_run;
   int   hold_left;
   int   recv_run;
   int   long_holds;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic field_type bump(input field_type n);
      return (n == '1) ? n : n + 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic line_class_type close_current_line();
      line_class_type cls;
      if (slash_wait) seen_code = 1'b1;
      if (!seen_text) begin
         cls = LC_EMPTY;
         n_empty = bump(n_empty);
      end else if (seen_code) begin
         cls = LC_CODE;
         n_code = bump(n_code);
      end else begin
         cls = LC_COMMENT;
         n_comment = bump(n_comment);
      end
      slash_wait   = 1'b0;
      star_wait    = 1'b0;
      skip_rest    = 1'b0;
      seen_code    = 1'b0;
      seen_text    = 1'b0;
      line_started = 1'b0;
      return cls;
   endfunction

   task automatic predict_line(input opcode_type op, input byte_type b);
      line_report_type res;
      logic            ws;
      if (op == OP_EOF) begin
         res.line_class    = line_started ? close_current_line() : LC_NONE;
         res.empty_lines   = n_empty;
         res.comment_lines = n_comment;
         res.code_lines    = n_code;
         res.file_done     = 1'b1;
         expected_lines.push_back(res);
         in_block  = 1'b0;
         n_empty   = '0;
         n_comment = '0;
         n_code    = '0;
      end else begin
         line_started = 1'b1;
         ws = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
         if (!skip_rest) begin
            if (b == CH_NUL) begin
               // a zero byte ends the scan like a line comment
               if (slash_wait) seen_code = 1'b1;
               slash_wait = 1'b0;
               star_wait  = 1'b0;
               skip_rest  = 1'b1;
            end else begin
               if (!ws) seen_text = 1'b1;
               if (in_block) begin
                  if (star_wait && b == CH_SLASH) begin
                     in_block  = 1'b0;
                     star_wait = 1'b0;
                  end else begin
                     star_wait = (b == CH_STAR);
                  end
               end else if (slash_wait) begin
                  slash_wait = 1'b0;
                  if (b == CH_STAR) begin
                     in_block  = 1'b1;
                     star_wait = 1'b0;
                  end else if (b == CH_SLASH) begin
                     skip_rest = 1'b1;
                  end else begin
                     seen_code = 1'b1;
                  end
               end else if (b == CH_SLASH) begin
                  slash_wait = 1'b1;
               end else if (!ws) begin
                  seen_code = 1'b1;
               end
            end
         end
         if (b == CH_NL) begin
            res.line_class    = close_current_line();
            res.empty_lines   = n_empty;
            res.comment_lines = n_comment;
            res.code_lines    = n_code;
            res.file_done     = 1'b0;
            expected_lines.push_back(res);
         end
      end
   endtask

   // Monitor: check the response first, then predict from the request taken at this edge.
   always @(posedge clock) begin
      line_report_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_lines.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected response: class %0d counts %0d/%0d/%0d done %0b",
                           rsp_if.line_class, rsp_if.empty_lines, rsp_if.comment_lines,
                           rsp_if.code_lines, rsp_if.file_done);
               error_count++;
            end else begin
               want = expected_lines.pop_front();
               if (rsp_if.line_class !== want.line_class ||
                   rsp_if.empty_lines !== want.empty_lines ||
                   rsp_if.comment_lines !== want.comment_lines ||
                   rsp_if.code_lines !== want.code_lines ||
                   rsp_if.file_done !== want.file_done) begin
                  if (error_count < 10)
                     $display({"mismatch: expected class %0d counts %0d/%0d/%0d done %0b,",
                               " got class %0d counts %0d/%0d/%0d done %0b"},
                              want.line_class, want.empty_lines, want.comment_lines,
                              want.code_lines, want.file_done, rsp_if.line_class,
                              rsp_if.empty_lines, rsp_if.comment_lines,
                              rsp_if.code_lines, rsp_if.file_done);
                  error_count++;
               end
            end
         end
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            predict_line(req_if.opcode, req_if.data_byte);
            requests_taken++;
         end
      end
   end

   // Driver: hold a request until taken, then idle for a random gap or send the next one.
   always @(negedge clock) begin
      text_request_type item;
      logic             drive_valid;
      opcode_type       drive_op;
      byte_type         drive_byte;
      drive_valid = req_if.valid;
      drive_op    = req_if.opcode;
      drive_byte  = req_if.data_byte;
      if (reset) begin
         drive_valid = 1'b0;
      end else if (!(req_if.valid && !req_taken)) begin
         drive_valid = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else begin
            // a pause marker waits until every expected line has come back
            if (pending_requests.size() > 0 && pending_requests[0].pause &&
                expected_lines.size() == 0)
               void'(pending_requests.pop_front());
            if (pending_requests.size() > 0 && !pending_requests[0].pause) begin
               item        = pending_requests.pop_front();
               drive_valid = 1'b1;
               drive_op    = item.opcode;
               drive_byte  = item.data_byte;
               if (send_run > 0) begin
                  send_run--;
                  send_gap = 0;
               end else begin
                  send_gap = pick_gap();
                  if ($urandom_range(0, 49) == 0) send_run = $urandom_range(30, 120);
               end
            end
         end
      end
      req_if.valid     <= drive_valid;
      req_if.opcode    <= drive_op;
      req_if.data_byte <= drive_byte;
   end

   // Receiver: random back-pressure plus two long hold-offs while requests keep coming.
   always @(negedge clock) begin
      logic ready_now;
      ready_now = 1'b0;
      if (!reset) begin
         if (hold_left == 0 && ((long_holds == 0 && requests_taken >= 150) ||
                                (long_holds == 1 && requests_taken >= 500))) begin
            hold_left = 250;
            long_holds++;
         end
         if (hold_left > 0) begin
            hold_left--;
         end else if (recv_run > 0) begin
            recv_run--;
            ready_now = 1'b1;
         end else begin
            ready_now = 1'b1;
            hold_left = pick_gap();
            if ($urandom_range(0, 49) == 0) recv_run = $urandom_range(30, 120);
         end
      end
      rsp_if.ready <= ready_now;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic add_byte(input byte_type b);
      text_request_type item;
      item.pause     = 1'b0;
      item.opcode    = OP_BYTE;
      item.data_byte = b;
      pending_requests.push_back(item);
      items_queued++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(byte_type'(s[i]));
   endtask

   task automatic add_eof(input byte_type b);
      text_request_type item;
      item.pause     = 1'b0;
      item.opcode    = OP_EOF;
      item.data_byte = b;
      pending_requests.push_back(item);
      items_queued++;
   endtask

   task automatic add_pause();
      text_request_type item;
      item.pause     = 1'b1;
      item.opcode    = OP_BYTE;
      item.data_byte = CH_NUL;
      pending_requests.push_back(item);
   endtask

   task automatic add_token();
      byte_type spaces[5];
      int       n;
      spaces = '{CH_SPACE, CH_TAB, 8'h0B, 8'h0C, CH_CR};
      case ($urandom_range(0, 13))
         0, 1: begin
            n = $urandom_range(1, 3);
            repeat (n) add_byte(spaces[$urandom_range(0, 4)]);
         end
         2, 3, 4: begin
            n = $urandom_range(1, 4);
            repeat (n) add_byte(byte_type'($urandom_range(8'h21, 8'h7E)));
         end
         5:  add_text("/*");
         6:  add_text("*/");
         7:  add_text("//");
         8:  add_byte(CH_SLASH);
         9:  add_byte(CH_STAR);
         10: add_byte(CH_NUL);
         11: add_text("/*/");
         12: add_byte(byte_type'($urandom_range(128, 255)));
         default: add_byte(byte_type'($urandom_range(0, 255)));
      endcase
   endtask

   initial begin
      int lines;
      int tokens;
      req_if.valid     = 1'b0;
      req_if.opcode    = OP_BYTE;
      req_if.data_byte = CH_NUL;
      rsp_if.ready     = 1'b0;
      in_block     = 1'b0;
      slash_wait   = 1'b0;
      star_wait    = 1'b0;
      skip_rest    = 1'b0;
      seen_code    = 1'b0;
      seen_text    = 1'b0;
      line_started = 1'b0;
      n_empty      = '0;
      n_comment    = '0;
      n_code       = '0;

      // empty file, then a single empty line
      add_eof(8'hFF);
      add_text("\n");
      add_eof(CH_NUL);
      // block comment across lines, closed with code after it and no final newline
      add_text("/*\n*/x");
      add_eof(8'h80);
      // lone slash before newline, line comment, slash before a zero byte
      add_text("/\n//\n/");
      add_byte(CH_NUL);
      add_text("\n");
      // zero byte first: the rest of the line is ignored
      add_byte(CH_NUL);
      add_text("x\n");
      // high byte, tab and a slash right before end of file
      add_byte(8'hFF);
      add_byte(CH_TAB);
      add_byte(CH_SLASH);
      add_eof(8'h7F);
      add_pause();

      // random files: mostly text-like lines, some noise bytes
      while (items_queued < TARGET_ITEMS) begin
         lines = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 6);
         repeat (lines) begin
            tokens = $urandom_range(0, 6);
            repeat (tokens) add_token();
            add_byte(CH_NL);
         end
         if ($urandom_range(0, 1) == 1) begin
            tokens = $urandom_range(0, 4);
            repeat (tokens) add_token();
         end
         add_eof(byte_type'($urandom_range(0, 255)));
         if ($urandom_range(0, 9) == 0) add_pause();
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_if.valid) @(posedge clock);
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_lines.size() != 0) error_count++;
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
